[hw/rtl/eafr_pkg.sv]
// shared types, constants and helpers of the escaped api frame receiver
package eafr_pkg;

    // frame store geometry
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int END_W       = 17;
    localparam int PAY_W       = 6;
    localparam int KIND_W      = 2;
    localparam int NUM_CODES   = 4;
    localparam int TYPE_IDX    = 2;

    // link control bytes
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;
    localparam logic [PAY_W-1:0] PAY_MAX = '1;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_CODE_COMMAND_REPLY = 8'd0,
        CFG_CODE_SEND_STATUS   = 8'd1,
        CFG_CODE_RX_PLAIN      = 8'd2,
        CFG_CODE_RX_EXPLICIT   = 8'd3
    } cfg_index_t;

    // type code reset values, by kind
    localparam logic [7:0] CODE_RESET [NUM_CODES] = '{8'd136, 8'd139, 8'd144, 8'd145};

    // receive phase, one-hot
    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_LEN_HI = 6'b000010,
        PH_LEN_LO = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CHECK  = 6'b010000,
        PH_EMIT   = 6'b100000
    } phase_t;

    // decoded link byte from the unescape stage
    typedef struct packed {
        logic       swallow;   // escape marker, no data this transaction
        logic       resync;    // bare control byte or bad escape
        logic [7:0] data;
    } unesc_t;

    // end-of-frame offset (length + 2 minus payload size) by kind
    function automatic logic [END_W-1:0] size_offset(input logic [KIND_W-1:0] kind);
        logic [END_W-1:0] off;
        case (kind)
            2'd0:    off = END_W'(7);
            2'd1:    off = END_W'(9);
            2'd2:    off = END_W'(14);
            2'd3:    off = END_W'(20);
            default: off = END_W'(7);
        endcase
        return off;
    endfunction

endpackage

[hw/rtl/escaped_api_frame_receiver.sv]
// Escaped API frame receiver: one raw link byte per transaction on the s_ side.
// While a frame is being received s_tready stays high for every byte; the frame
// data goes into a 64-byte frame store (a synchronous RAM) from index 2 on.
// After a good checksum on a frame whose type matches one of the four code
// registers, s_tready drops and the stored bytes, type byte first, are read out
// of the store one per cycle while m_tready allows (the store has a single read
// port) and sent as a run closed by m_tlast, the input held off until the last
// read. Bad frames, unknown types, bare control bytes and overlong frames
// produce nothing; the store needs no clearing after reset. The user must write
// code registers through the cfg_ port only while idle, which is not enforced.
module escaped_api_frame_receiver import eafr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input link bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    // frame byte run
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] frame_byte
    output logic        m_tlast,     // last_byte
    output logic [7:0]  m_tuser,     // [1:0] frame_kind, [7:2] payload_size
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    phase_t             phase_reg, phase_next, cur_phase;
    logic [END_W-1:0]   fe_reg, fe_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         type_reg, type_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [PAY_W-1:0]   pay_reg, pay_next;
    logic [CNT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_tlast_reg, m_tlast_next;
    logic [7:0]         m_tuser_reg, m_tuser_next;
    logic [7:0]         code_reg [NUM_CODES];

    logic               in_take;
    unesc_t             uo;
    logic               ram_we;
    logic               rd_issue;
    logic               rd_last;
    logic               match;
    logic [KIND_W-1:0]  match_kind;
    logic [END_W-1:0]   off;
    logic [END_W-1:0]   diff;
    logic [PAY_W-1:0]   pay_calc;

    assign s_tready  = (phase_reg != PH_EMIT);
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    eafr_unesc u_unesc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (in_take),
        .raw     (s_tdata),
        .uo      (uo)
    );

    eafr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg[IDX_W-1:0]),
        .wdata (uo.data),
        .re    (rd_issue),
        .raddr (rd_addr_reg[IDX_W-1:0]),
        .rdata (m_tdata)
    );

    // type match, lowest kind wins
    always_comb begin
        match      = 1'b0;
        match_kind = '0;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (type_reg == code_reg[k]) begin
                match      = 1'b1;
                match_kind = KIND_W'(k);
            end
        end
    end

    // payload size, clamped at zero and saturated
    always_comb begin
        off  = size_offset(match_kind);
        diff = fe_reg - off;
        if (fe_reg <= off) begin
            pay_calc = '0;
        end else if (diff > END_W'(PAY_MAX)) begin
            pay_calc = PAY_MAX;
        end else begin
            pay_calc = diff[PAY_W-1:0];
        end
    end

    // receive and read-out sequencing
    always_comb begin
        phase_next    = phase_reg;
        fe_next       = fe_reg;
        wr_idx_next   = wr_idx_reg;
        sum_next      = sum_reg;
        type_next     = type_reg;
        kind_next     = kind_reg;
        pay_next      = pay_reg;
        rd_addr_next  = rd_addr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        cur_phase     = phase_reg;
        rd_issue      = 1'b0;
        rd_last       = (rd_addr_reg + CNT_W'(1)) == wr_idx_reg;

        if (in_take && !uo.swallow) begin
            sum_next  = sum_reg + uo.data;
            cur_phase = uo.resync ? PH_HUNT : phase_reg;
            case (cur_phase)
                PH_LEN_HI: begin
                    fe_next    = {1'b0, uo.data, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    fe_next     = (fe_reg | END_W'(uo.data)) + END_W'(2);
                    wr_idx_next = CNT_W'(TYPE_IDX);
                    sum_next    = '0;
                    phase_next  = PH_DATA;
                end
                PH_DATA: begin
                    if (wr_idx_reg >= CNT_W'(STORE_DEPTH)) begin
                        phase_next = PH_HUNT;
                    end else begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                        if (wr_idx_reg == CNT_W'(TYPE_IDX)) begin
                            type_next = uo.data;
                        end
                        if (END_W'(wr_idx_next) >= fe_reg) begin
                            phase_next = PH_CHECK;
                        end else if (wr_idx_next == CNT_W'(STORE_DEPTH)) begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_HUNT;
                    if (sum_next == SUM_GOOD && match) begin
                        phase_next   = PH_EMIT;
                        kind_next    = match_kind;
                        pay_next     = pay_calc;
                        rd_addr_next = CNT_W'(TYPE_IDX);
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (uo.data == START_BYTE) begin
                        phase_next = PH_LEN_HI;
                        fe_next    = '0;
                    end
                end
            endcase
        end

        // output register frees on a taken transaction
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // read the next stored byte straight into the output stage
        if (phase_reg == PH_EMIT && (!m_tvalid_reg || m_tready)) begin
            rd_issue      = 1'b1;
            m_tvalid_next = 1'b1;
            m_tlast_next  = rd_last;
            m_tuser_next  = {pay_reg, kind_reg};
            rd_addr_next  = rd_addr_reg + CNT_W'(1);
            if (rd_last) begin
                phase_next = PH_HUNT;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            fe_reg       <= '0;
            wr_idx_reg   <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            fe_reg       <= fe_next;
            wr_idx_reg   <= wr_idx_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload side registers
    always_ff @(posedge aclk) begin
        type_reg    <= type_next;
        kind_reg    <= kind_next;
        pay_reg     <= pay_next;
        rd_addr_reg <= rd_addr_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    // type code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CODES; k++) begin
                code_reg[k] <= CODE_RESET[k];
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CODE_COMMAND_REPLY: code_reg[0] <= cfg_data;
                CFG_CODE_SEND_STATUS:   code_reg[1] <= cfg_data;
                CFG_CODE_RX_PLAIN:      code_reg[2] <= cfg_data;
                CFG_CODE_RX_EXPLICIT:   code_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // the store is never written while it is being read out
    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> phase_reg != PH_EMIT)
        else $error("frame store written during read-out");

    // write index never runs past the store
    a_wr_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_idx_reg <= CNT_W'(STORE_DEPTH))
        else $error("write index beyond frame store");

    // read-out stays inside the bytes written for this frame
    a_rd_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_EMIT |-> rd_addr_reg < wr_idx_reg)
        else $error("read-out address past end of frame");

    // the last read ends the run and reopens the input
    a_last_ends_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue && rd_last |=> phase_reg == PH_HUNT && m_tlast)
        else $error("run did not end after its last byte");

endmodule

[hw/rtl/eafr_ram.sv]
// generic single-write, single-read ram with registered read data
module eafr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/eafr_unesc.sv]
// link byte unescape stage with its pending-escape flag
module eafr_unesc import eafr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] raw,
    output unesc_t     uo
);

    logic esc_pend_reg;
    logic esc_pend_next;
    logic [7:0] flipped;
    logic special;

    // unescape and classify the byte
    always_comb begin
        flipped = esc_pend_reg ? (raw ^ ESC_XOR) : raw;
        special = (flipped == XON_BYTE) || (flipped == XOFF_BYTE) ||
                  (flipped == ESC_BYTE) || (flipped == START_BYTE);
        uo.swallow = (raw == ESC_BYTE);
        if (special) begin
            uo.data   = flipped;
            uo.resync = !esc_pend_reg;
        end else begin
            uo.data   = raw;
            uo.resync = esc_pend_reg;
        end
    end

    // escape flag is set by the marker and cleared by any other byte
    always_comb begin
        esc_pend_next = esc_pend_reg;
        if (take) begin
            esc_pend_next = (raw == ESC_BYTE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pend_reg <= 1'b0;
        end else begin
            esc_pend_reg <= esc_pend_next;
        end
    end

endmodule

[dv/escaped_api_frame_receiver_test.sv]
// self-checking testbench of the escaped api frame receiver, with its frame scoreboard
module escaped_api_frame_receiver_test;
    import eafr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run control
    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int SEG_BYTES    = 8;
    localparam int SEG_BEATS    = 2;

    // declared length + 2 minus payload size, by kind
    localparam int END_TO_PAYLOAD [NUM_CODES] = '{7, 9, 14, 20};
    localparam int PAYLOAD_TOP = (1 << PAY_W) - 1;

    // bytes that stress the unescape logic and the field extremes
    localparam logic [7:0] EDGE_BYTES [6] = '{XON_BYTE, XOFF_BYTE, ESC_BYTE, START_BYTE,
                                              8'h00, 8'hFF};

    // hand-built link sequences: double escape, bad escape of a start byte,
    // bare xon inside a frame, bare start restarting a frame
    localparam logic [7:0] OPENING_BYTES [25] = '{
        8'h00, 8'hFF,
        8'h7D, 8'h7D, 8'h31,
        8'h7D, 8'h7E, 8'h00, 8'h00, 8'h88, 8'h77,
        8'h7E, 8'h00, 8'h05, 8'h8B, 8'h11,
        8'h7E, 8'h00, 8'h04, 8'h90, 8'h7E, 8'h00, 8'h00, 8'h90, 8'h6F
    };

    typedef enum int {
        HUNT_START,
        LEN_MSB,
        LEN_LSB,
        FRAME_DATA,
        FRAME_SUM
    } link_phase_t;

    typedef struct packed {
        logic [7:0]        frame_byte;
        logic              last_byte;
        logic [KIND_W-1:0] frame_kind;
        logic [PAY_W-1:0]  payload_size;
    } frame_beat_t;

    // tracks the link decoder and holds the frame bytes still to come out
    class frame_scoreboard;
        logic [7:0]  code [NUM_CODES];
        link_phase_t phase;
        bit          esc_pending;
        int          frame_end;
        int          wr_idx;
        logic [7:0]  run_sum;
        logic [7:0]  store [STORE_DEPTH];
        frame_beat_t expected_beats [$];
        int          beats_predicted;
        int          beats_checked;
        int          fail_count;

        function new();
            for (int k = 0; k < NUM_CODES; k++) code[k] = CODE_RESET[k];
            phase           = HUNT_START;
            esc_pending     = 1'b0;
            frame_end       = 0;
            wr_idx          = 0;
            run_sum         = 8'h00;
            beats_predicted = 0;
            beats_checked   = 0;
            fail_count      = 0;
        endfunction

        function void set_code(int idx, logic [7:0] value);
            code[idx] = value;
        endfunction

        function int beats_pending();
            return expected_beats.size();
        endfunction

        // one accepted link byte
        function void take_link_byte(logic [7:0] raw);
            logic [7:0]  b;
            bit          esc;
            bit          ctrl;
            int          kind;
            int          pay;
            int          n;
            frame_beat_t beat;

            b = raw;
            if (b == ESC_BYTE) begin
                esc_pending = 1'b1;
                return;
            end
            esc = esc_pending;
            if (esc) b = b ^ ESC_XOR;
            ctrl = (b == XON_BYTE) || (b == XOFF_BYTE) || (b == ESC_BYTE) || (b == START_BYTE);
            // bare control byte resyncs, bad escape keeps the raw byte and resyncs
            if (ctrl) begin
                if (!esc) phase = HUNT_START;
            end else if (esc) begin
                b     = b ^ ESC_XOR;
                phase = HUNT_START;
            end
            esc_pending = 1'b0;
            run_sum     = run_sum + b;

            case (phase)
                LEN_MSB: begin
                    frame_end = int'(b) << 8;
                    phase     = LEN_LSB;
                end
                LEN_LSB: begin
                    frame_end = (frame_end | int'(b)) + 2;
                    wr_idx    = 2;
                    run_sum   = 8'h00;
                    phase     = FRAME_DATA;
                end
                FRAME_DATA: begin
                    if (wr_idx >= STORE_DEPTH) begin
                        phase = HUNT_START;
                    end else begin
                        store[wr_idx] = b;
                        wr_idx++;
                        if (wr_idx >= frame_end) phase = FRAME_SUM;
                        else if (wr_idx == STORE_DEPTH) phase = HUNT_START;
                    end
                end
                FRAME_SUM: begin
                    phase = HUNT_START;
                    if (run_sum == SUM_GOOD) begin
                        // lowest matching kind wins
                        kind = -1;
                        for (int k = 0; k < NUM_CODES; k++)
                            if (kind < 0 && store[TYPE_IDX] == code[k]) kind = k;
                        if (kind >= 0) begin
                            pay = (frame_end > END_TO_PAYLOAD[kind]) ?
                                  frame_end - END_TO_PAYLOAD[kind] : 0;
                            if (pay > PAYLOAD_TOP) pay = PAYLOAD_TOP;
                            n = wr_idx - 2;
                            for (int k = 0; k < n; k++) begin
                                beat.frame_byte   = store[TYPE_IDX + k];
                                beat.last_byte    = (k == n - 1);
                                beat.frame_kind   = KIND_W'(kind);
                                beat.payload_size = PAY_W'(pay);
                                expected_beats.push_back(beat);
                                beats_predicted++;
                            end
                        end
                    end
                end
                default: begin
                    phase = HUNT_START;
                    if (b == START_BYTE) begin
                        phase     = LEN_MSB;
                        frame_end = 0;
                    end
                end
            endcase
        endfunction

        // one accepted output transaction against the oldest expected beat
        function void check_frame_beat(logic [7:0] data, logic last, logic [7:0] user);
            frame_beat_t want;

            if (expected_beats.size() == 0) begin
                $error("frame_byte %02h arrived with nothing expected", data);
                fail_count++;
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (data !== want.frame_byte) begin
                $error("frame_byte: expected %02h, actual %02h", want.frame_byte, data);
                fail_count++;
            end
            if (last !== want.last_byte) begin
                $error("last_byte: expected %0d, actual %0d", want.last_byte, last);
                fail_count++;
            end
            if (user[KIND_W-1:0] !== want.frame_kind) begin
                $error("frame_kind: expected %0d, actual %0d", want.frame_kind,
                       user[KIND_W-1:0]);
                fail_count++;
            end
            if (user[KIND_W +: PAY_W] !== want.payload_size) begin
                $error("payload_size: expected %0d, actual %0d", want.payload_size,
                       user[KIND_W +: PAY_W]);
                fail_count++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [7:0] m_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    frame_scoreboard sb;
    int  link_bytes    = 0;
    int  idle_cycles   = 0;
    bit  sender_steady = 1'b0;
    int  ready_left    = 0;
    bit  ready_phase   = 1'b0;

    escaped_api_frame_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // output stall pattern: long ready stretches mixed with short and long stalls
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_phase = !ready_phase;
            if (ready_phase)
                ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            else
                ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
        end
        ready_left--;
        m_tready = ready_phase;
    end

    // output transactions
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_frame_beat(m_tdata, m_tlast, m_tuser);
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int link_gap();
        int r;
        if (sender_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] biased_byte();
        if ($urandom_range(0, 3) == 0) return EDGE_BYTES[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // one link byte transaction, after a random gap
    task automatic send_link_byte(input logic [7:0] b);
        int gap;
        gap = link_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        sb.take_link_byte(b);
        link_bytes++;
    endtask

    // builds an escaped frame and sends its first cut raw bytes (all if cut < 0)
    task automatic send_frame(input logic [7:0] type_code, input int declared,
                              input bit bad_sum, input int cut);
        logic [7:0] body [$];
        logic [7:0] raw [$];
        logic [7:0] d;
        logic [7:0] sum;
        int         n;

        n = (declared == 0) ? 1 : ((declared < STORE_DEPTH) ? declared : STORE_DEPTH - 1);
        body.push_back(8'(declared >> 8));
        body.push_back(8'(declared));
        sum = 8'h00;
        for (int i = 0; i < n; i++) begin
            d   = (i == 0) ? type_code : biased_byte();
            sum = sum + d;
            body.push_back(d);
        end
        d = SUM_GOOD - sum;
        if (bad_sum) d = d ^ 8'($urandom_range(1, 255));
        body.push_back(d);
        raw.push_back(START_BYTE);
        foreach (body[i]) begin
            if (body[i] == ESC_BYTE || body[i] == START_BYTE ||
                body[i] == XON_BYTE || body[i] == XOFF_BYTE) begin
                raw.push_back(ESC_BYTE);
                raw.push_back(body[i] ^ ESC_XOR);
            end else begin
                raw.push_back(body[i]);
            end
        end
        foreach (raw[i]) if (cut < 0 || i < cut) send_link_byte(raw[i]);
    endtask

    // sender holds off until the block has drained everything expected
    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.beats_pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_code(input cfg_index_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_code(int'(idx), value);
    endtask

    task automatic program_codes(input logic [7:0] reply, input logic [7:0] status,
                                 input logic [7:0] plain, input logic [7:0] expl);
        wait_for_idle();
        write_code(CFG_CODE_COMMAND_REPLY, reply);
        write_code(CFG_CODE_SEND_STATUS, status);
        write_code(CFG_CODE_RX_PLAIN, plain);
        write_code(CFG_CODE_RX_EXPLICIT, expl);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // one random link sequence: mostly good frames, some broken ones and noise
    task automatic send_random_sequence();
        int          r;
        int          len;
        logic [7:0]  pick;

        sender_steady = ($urandom_range(0, 3) == 0);
        r    = $urandom_range(0, 99);
        len  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        pick = sb.code[$urandom_range(0, NUM_CODES - 1)];
        if (r < 55) begin
            send_frame(pick, len, 1'b0, -1);
        end else if (r < 63) begin
            send_frame(8'($urandom), len, 1'b0, -1);
        end else if (r < 71) begin
            send_frame(pick, len, 1'b1, -1);
        end else if (r < 76) begin
            send_frame(pick, $urandom_range(40, 70), 1'b0, -1);
        end else if (r < 78) begin
            send_frame(pick, $urandom_range(256, 65535), 1'b0, -1);
        end else if (r < 90) begin
            repeat ($urandom_range(1, 6)) send_link_byte(biased_byte());
        end else begin
            send_frame(pick, len, 1'b0, $urandom_range(1, 5));
        end
    endtask

    task automatic run_random_segment(input bit pause_midway);
        int start_bytes;
        int start_beats;
        bit paused;

        start_bytes = link_bytes;
        start_beats = sb.beats_predicted;
        paused      = 1'b0;
        while (link_bytes - start_bytes < SEG_BYTES ||
               sb.beats_predicted - start_beats < SEG_BEATS) begin
            send_random_sequence();
            if (pause_midway && !paused && link_bytes - start_bytes >= SEG_BYTES / 2) begin
                wait_for_idle();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = 8'h00;
        cfg_data  = 8'h00;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: escape corner cases, then short frames at reset codes and one unknown type
        foreach (OPENING_BYTES[i]) send_link_byte(OPENING_BYTES[i]);
        send_frame(CODE_RESET[1], 1, 1'b0, -1);
        send_frame(CODE_RESET[2], 14, 1'b0, -1);
        send_frame(CODE_RESET[3], 3, 1'b1, -1);
        send_frame(8'h55, 2, 1'b0, -1);

        // extreme and control-byte codes, opened by a longest-run frame
        program_codes(8'h00, 8'hFF, START_BYTE, XON_BYTE);
        send_frame(XON_BYTE, STORE_DEPTH - 2, 1'b0, -1);
        run_random_segment(1'b0);

        // duplicate codes, with a full drain in the middle
        program_codes(8'h42, 8'h42, ESC_BYTE, 8'h42);
        run_random_segment(1'b1);

        wait_for_idle();
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
